/* src/sbcb_pkg.sv */
// Package for the swept box brush clip: widths, fixed-point constants, coordinate extract, divider request.
// No dependencies.
package sbcb_pkg;
  localparam int MAX_SIDES  = 64;
  localparam int SIDE_W     = 6;
  localparam int COORD_BITS = 21;
  localparam int FRAC_W     = 18;
  localparam int DIST_W     = 48;
  localparam int DIV_BITS   = 18;
  localparam logic signed [FRAC_W-1:0] ONE_Q16   = 18'sd65536;
  localparam logic signed [FRAC_W-1:0] MONE_Q16  = -18'sd65536;
  localparam logic signed [DIST_W-1:0] EPS_Q22   = 48'sd131072;

  typedef logic signed [DIST_W-1:0] dist_t;

  function automatic logic signed [COORD_BITS-1:0] coord_f(input logic [62:0] r,
                                                           input int k);
    coord_f = r[21*k +: COORD_BITS];
  endfunction

  typedef struct packed {
    logic                     start;
    logic signed [DIST_W-1:0] num;
    logic signed [DIST_W-1:0] den;
  } div_req_t;
endpackage

/* src/sbcb_div.sv */
// Iterative restoring divider: num*65536/den, one quotient bit a cycle.
// Depends on sbcb_pkg.
module sbcb_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbcb_pkg::div_req_t                req,
  output logic                              done,
  output logic signed [sbcb_pkg::FRAC_W-1:0] quot
);
  import sbcb_pkg::*;

  logic [DIST_W-1:0]  den_r, rem_r, rem_nxt;
  logic [DIST_W+15:0] dvd_r, dvd_nxt;
  logic [DIV_BITS:0]  q_r, q_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [DIST_W:0]    trial;
  logic [DIST_W-1:0]  mag;
  logic               q_big;

  // bits above DIV_BITS only set the saturation flag
  localparam int STEPS = DIST_W + 16;

  always_comb begin
    mag = req.num[DIST_W-1] ? DIST_W'(-req.num) : DIST_W'(req.num);
    trial = {rem_r, dvd_r[DIST_W+15]} - {1'b0, den_r};
    rem_nxt = rem_r; dvd_nxt = dvd_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0; dvd_nxt = {mag, 16'd0}; q_nxt = '0;
      cnt_nxt = 6'(STEPS - 1); busy_nxt = 1'b1; neg_nxt = req.num[DIST_W-1];
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIST_W+14:0], 1'b0};
      if (!trial[DIST_W]) begin
        rem_nxt = trial[DIST_W-1:0];
        q_nxt = {q_r[DIV_BITS-1:0], 1'b1} | {q_r[DIV_BITS], {DIV_BITS{1'b0}}};
      end else begin
        rem_nxt = {rem_r[DIST_W-2:0], dvd_r[DIST_W+15]};
        q_nxt = {q_r[DIV_BITS-1:0], 1'b0} | {q_r[DIV_BITS], {DIV_BITS{1'b0}}};
      end
      // sticky top bit marks overflow beyond the saturation range
      if (q_r[DIV_BITS-1]) q_nxt[DIV_BITS] = 1'b1;
      if (cnt_r == '0) begin busy_nxt = 1'b0; done_nxt = 1'b1; end
      else cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    if (req.start) den_r <= req.den;
    rem_r <= rem_nxt; dvd_r <= dvd_nxt; q_r <= q_nxt; neg_r <= neg_nxt;
  end

  always_comb begin
    q_big = q_r[DIV_BITS] || q_r[DIV_BITS-1];
    if (neg_r)
      quot = (q_big && q_r[DIV_BITS-2:0] != '0) || q_r[DIV_BITS] ||
             (q_r[DIV_BITS-1] && q_r[DIV_BITS-2:0] != '0) ?
             -18'sd131072 : -$signed({1'b0, q_r[DIV_BITS-2:0]}) -
             (q_r[DIV_BITS-1] ? 18'sd131072 : 18'sd0);
    else
      quot = q_big ? 18'sd131071 : $signed({1'b0, q_r[DIV_BITS-2:0]});
  end
  assign done = done_r;
endmodule

/* src/swept_box_convex_brush_clip.sv */
// Top level of the swept box brush clip: sequencer, shared multiplier, state.
// Depends on sbcb_pkg and sbcb_div.
//
// From acceptance to the next acceptance, a plane beat that needs a crossing
// fraction passes through acceptance, the products through one shared 21x16
// multiplier, an evaluate state, a divider start state, the 64-step bit-serial
// divider and a finish state. A plane without a crossing skips the divider, and
// a side of an already rejected brush goes from acceptance straight to finish.
// A last side adds an output state, which waits while the previous result still
// waits in the output register. Begin-trace beats are taken in the idle state.
// in_stall is high while a beat is at work. A result waits in the output register
// without holding the input.
module swept_box_convex_brush_clip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [20:0] in_plane_offset,
  input  logic [5:0]  in_side_index,
  input  logic [31:0] in_brush_contents,
  input  logic        in_last_side,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_trace_fraction,
  output logic [5:0]  out_hit_side,
  output logic [31:0] out_hit_contents,
  output logic        out_start_solid,
  output logic        out_all_solid,
  output logic        out_brush_updated
);
  import sbcb_pkg::*;

  localparam logic [2:0] CFG_START = 3'd0, CFG_END = 3'd1, CFG_MINS = 3'd2,
                         CFG_MAXS = 3'd3, CFG_POINT = 3'd4, CFG_POS = 3'd5;
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_EVAL = 3'd2,
                         S_DIV = 3'd3, S_WAITDIV = 3'd4, S_FIN = 3'd5,
                         S_OUT = 3'd6;

  logic [62:0] start_r, end_r, mins_r, maxs_r;
  logic        point_r, pos_r;
  logic [2:0]  st_r;
  logic [3:0]  step_r;
  logic signed [15:0] n_r [3];
  logic signed [20:0] ofs_r;
  logic [5:0]  side_r;
  logic [31:0] cont_r;
  logic        last_r;
  dist_t       acc_ofs_r, acc1_r, acc2_r, prod_r;
  logic        getout_r, startout_r, rej_r, ssolid_r, asolid_r;
  logic [16:0] best_r;
  logic signed [FRAC_W-1:0] enter_r, leave_r;
  logic [5:0]  lead_r, bside_r;
  logic [31:0] bcont_r;
  logic        is_enter_r;
  logic        ov_r;
  logic [16:0] o_frac_r;
  logic [5:0]  o_side_r;
  logic [31:0] o_cont_r;
  logic        o_ss_r, o_as_r, o_upd_r;

  div_req_t dreq;
  logic     ddone;
  logic signed [FRAC_W-1:0] dq;
  sbcb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  // shared multiplier operands: steps 0-2 box, 3-5 start, 6-8 end
  logic [1:0]  axis;
  logic signed [COORD_BITS-1:0] mc;
  logic signed [15:0] mn;
  dist_t plane_d, d1, d2;
  logic  bump;
  always_comb begin
    case (step_r)
      4'd0, 4'd3, 4'd6, 4'd9: axis = 2'd0;
      4'd1, 4'd4, 4'd7:       axis = 2'd1;
      default:                axis = 2'd2;
    endcase
    mn = n_r[axis];
    if (step_r < 4'd3) mc = coord_f(mn[15] ? maxs_r : mins_r, int'(axis));
    else if (step_r < 4'd6) mc = coord_f(start_r, int'(axis));
    else mc = coord_f(end_r, int'(axis));
    bump = !point_r || pos_r;
    plane_d = DIST_W'(ofs_r) * 48'sd16384 - (bump ? acc_ofs_r : '0);
    d1 = acc1_r - plane_d;
    d2 = acc2_r - plane_d;
  end

  assign in_stall = (st_r != S_IDLE);
  wire in_acc = in_valid && !in_stall;

  logic [5:0] side_sat;
  assign side_sat = (in_side_index > 6'(MAX_SIDES - 1)) ? 6'(MAX_SIDES - 1) : in_side_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; end_r <= '0; mins_r <= '0; maxs_r <= '0;
      point_r <= 1'b0; pos_r <= 1'b0;
      st_r <= S_IDLE; step_r <= '0; ov_r <= 1'b0;
      best_r <= 17'd65536; bside_r <= '0; bcont_r <= '0;
      enter_r <= MONE_Q16; leave_r <= ONE_Q16; lead_r <= '0;
      {getout_r, startout_r, rej_r, ssolid_r, asolid_r} <= '0;
      dreq <= '0;
    end else begin
      if (st_r != S_EVAL) dreq.start <= 1'b0;
      if (ov_r && !out_stall && st_r != S_OUT) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START: start_r <= cfg_data;
          CFG_END:   end_r <= cfg_data;
          CFG_MINS:  mins_r <= cfg_data;
          CFG_MAXS:  maxs_r <= cfg_data;
          CFG_POINT: point_r <= cfg_data[0];
          CFG_POS:   pos_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: if (in_acc) begin
          if (in_cmd) begin
            best_r <= 17'd65536; bside_r <= '0; bcont_r <= '0;
            enter_r <= MONE_Q16; leave_r <= ONE_Q16; lead_r <= '0;
            {getout_r, startout_r, rej_r, ssolid_r, asolid_r} <= '0;
          end else begin
            n_r[0] <= in_normal_x; n_r[1] <= in_normal_y; n_r[2] <= in_normal_z;
            ofs_r <= in_plane_offset; side_r <= side_sat;
            cont_r <= in_brush_contents; last_r <= in_last_side;
            acc_ofs_r <= '0; acc1_r <= '0; acc2_r <= '0;
            step_r <= '0;
            st_r <= rej_r ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          // product registered in prod_r, accumulated at the next step
          prod_r <= DIST_W'(mc) * DIST_W'(mn);
          if (step_r != 4'd0) begin
            if (step_r <= 4'd3) acc_ofs_r <= acc_ofs_r + prod_r;
            else if (step_r <= 4'd6) acc1_r <= acc1_r + prod_r;
            else acc2_r <= acc2_r + prod_r;
          end
          if (step_r == 4'd9) st_r <= S_EVAL;
          else step_r <= step_r + 4'd1;
        end
        S_EVAL: begin
          st_r <= S_FIN;
          if (pos_r) begin
            if (d1 > 0) rej_r <= 1'b1;
          end else begin
            if (d2 > 0) getout_r <= 1'b1;
            if (d1 > 0) startout_r <= 1'b1;
            if (d1 > 0 && d2 >= d1) rej_r <= 1'b1;
            else if (d1 > 0 || d2 > 0) begin
              dreq.start <= 1'b1;
              is_enter_r <= d1 > d2;
              dreq.num <= (d1 > d2) ? d1 - EPS_Q22 : -(d1 + EPS_Q22);
              dreq.den <= (d1 > d2) ? d1 - d2 : d2 - d1;
              st_r <= S_DIV;
            end
          end
        end
        S_DIV: st_r <= S_WAITDIV;
        S_WAITDIV: if (ddone) begin
          if (is_enter_r) begin
            if (dq > enter_r) begin enter_r <= dq; lead_r <= side_r; end
          end else if (dq < leave_r) leave_r <= dq;
          st_r <= S_FIN;
        end
        S_FIN: st_r <= last_r ? S_OUT : S_IDLE;
        S_OUT: if (!ov_r || !out_stall) begin
          logic [16:0] nb;
          logic ns, na;
          logic [5:0] nside;
          logic [31:0] ncont;
          nb = best_r; ns = ssolid_r; na = asolid_r;
          nside = bside_r; ncont = bcont_r;
          if (!rej_r) begin
            if (pos_r) begin
              ns = 1'b1; na = 1'b1; nb = '0; ncont = cont_r;
            end else if (!startout_r) begin
              ns = 1'b1; if (!getout_r) na = 1'b1;
            end else if (enter_r < leave_r && enter_r > MONE_Q16 &&
                         enter_r < $signed({1'b0, best_r})) begin
              nb = enter_r[FRAC_W-1] ? 17'd0 : enter_r[16:0];
              nside = lead_r; ncont = cont_r;
            end
          end
          best_r <= nb; ssolid_r <= ns; asolid_r <= na;
          bside_r <= nside; bcont_r <= ncont;
          o_frac_r <= nb;
          o_side_r <= nside;
          o_cont_r <= ncont;
          o_ss_r <= ns; o_as_r <= na;
          o_upd_r <= nb != best_r || ns != ssolid_r || na != asolid_r;
          ov_r <= 1'b1;
          enter_r <= MONE_Q16; leave_r <= ONE_Q16; lead_r <= '0;
          {getout_r, startout_r, rej_r} <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_trace_fraction = o_frac_r;
  assign out_hit_side = o_side_r;
  assign out_hit_contents = o_cont_r;
  assign out_start_solid = o_ss_r;
  assign out_all_solid = o_as_r;
  assign out_brush_updated = o_upd_r;
endmodule
